// ===== rtl/char_lcd_4bit_init_and_write_assert.svh =====
// Assertion macros used by the LCD driver checker.
`ifndef CHAR_LCD_4BIT_INIT_AND_WRITE_ASSERT_SVH
`define CHAR_LCD_4BIT_INIT_AND_WRITE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define LCD4_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcd4 assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define LCD4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcd4 assertion failed");

`endif

// ===== rtl/lcd4_pkg.sv =====
// Types, constants and helper functions of the 4-bit character LCD driver.
package lcd4_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_POWER_UP    = 3'd0;
	localparam logic [2:0] REG_STEP        = 3'd1;
	localparam logic [2:0] REG_FORCE_RESET = 3'd2;
	localparam logic [2:0] REG_FOUR_BIT    = 3'd3;
	localparam logic [2:0] REG_DISP_OFF    = 3'd4;
	localparam logic [2:0] REG_CLEAR       = 3'd5;
	localparam logic [2:0] REG_ENTRY_MODE  = 3'd6;
	localparam logic [2:0] REG_DISP_ON     = 3'd7;

	// register reset values
	localparam logic [9:0] DEF_POWER_UP    = 10'd100;
	localparam logic [7:0] DEF_STEP        = 8'd10;
	localparam logic [7:0] DEF_FORCE_RESET = 8'h33;
	localparam logic [7:0] DEF_FOUR_BIT    = 8'h28;
	localparam logic [7:0] DEF_DISP_OFF    = 8'h08;
	localparam logic [7:0] DEF_CLEAR       = 8'h01;
	localparam logic [7:0] DEF_ENTRY_MODE  = 8'h06;
	localparam logic [7:0] DEF_DISP_ON     = 8'h0C;

	// request opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// init stages: two power-up waits, eight commands, done
	localparam logic [3:0] STG_WAIT1       = 4'd0;
	localparam logic [3:0] STG_FIRST_CMD   = 4'd2;
	localparam logic [3:0] STG_FORCE_LAST  = 4'd4;
	localparam logic [3:0] STG_FOUR_BIT    = 4'd5;
	localparam logic [3:0] STG_DISP_OFF    = 4'd6;
	localparam logic [3:0] STG_CLEAR       = 4'd7;
	localparam logic [3:0] STG_ENTRY_MODE  = 4'd8;
	localparam logic [3:0] STG_DONE        = 4'd10;

	// nibble phases
	localparam logic [2:0] PH_HI_EN  = 3'd0;
	localparam logic [2:0] PH_HI_LOW = 3'd1;
	localparam logic [2:0] PH_LO_EN  = 3'd2;
	localparam logic [2:0] PH_LO_LOW = 3'd3;
	localparam logic [2:0] PH_SETTLE = 3'd4;

	typedef struct packed {
		logic [9:0] power_up_ms;
		logic [7:0] step_ms;
		logic [7:0] cmd_force_reset;
		logic [7:0] cmd_four_bit;
		logic [7:0] cmd_display_off;
		logic [7:0] cmd_clear;
		logic [7:0] cmd_entry_mode;
		logic [7:0] cmd_display_on;
	} lcd4_cfg_t;

	typedef struct packed {
		logic [3:0] init_stage;
		logic [2:0] nibble_phase;
		logic [9:0] tick_count;
		logic [7:0] held_byte;
		logic       sending_data;
		logic       rs_level;
		logic       en_level;
		logic [3:0] nibble_level;
	} lcd4_state_t;

	typedef struct packed {
		logic       reg_select;
		logic       enable_pin;
		logic [3:0] bus_nibble;
		logic       init_done;
		logic       busy_res;
		logic       write_accepted;
		logic       write_done;
	} lcd4_res_t;

	function automatic logic [7:0] cmd_for_stage(input logic [3:0] stage, input lcd4_cfg_t cfg);
		logic [7:0] cmd;
		case (stage) inside
			[STG_FIRST_CMD:STG_FORCE_LAST]: cmd = cfg.cmd_force_reset;
			STG_FOUR_BIT:                   cmd = cfg.cmd_four_bit;
			STG_DISP_OFF:                   cmd = cfg.cmd_display_off;
			STG_CLEAR:                      cmd = cfg.cmd_clear;
			STG_ENTRY_MODE:                 cmd = cfg.cmd_entry_mode;
			default:                        cmd = cfg.cmd_display_on;
		endcase
		return cmd;
	endfunction

	// load a byte and raise EN with its high nibble
	function automatic lcd4_state_t start_byte(input lcd4_state_t s, input logic [7:0] b,
			input logic rs);
		lcd4_state_t r;
		r = s;
		r.held_byte    = b;
		r.rs_level     = rs;
		r.en_level     = 1'b1;
		r.nibble_level = b[7:4];
		r.nibble_phase = PH_HI_EN;
		r.tick_count   = '0;
		return r;
	endfunction

endpackage

// ===== rtl/lcd4_cfg_regs.sv =====
// Configuration register file of the LCD driver.
module lcd4_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [9:0]            cfg_data,
	output lcd4_pkg::lcd4_cfg_t   cfg
);
	import lcd4_pkg::*;

	lcd4_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_ms     <= DEF_POWER_UP;
			cfg_q.step_ms         <= DEF_STEP;
			cfg_q.cmd_force_reset <= DEF_FORCE_RESET;
			cfg_q.cmd_four_bit    <= DEF_FOUR_BIT;
			cfg_q.cmd_display_off <= DEF_DISP_OFF;
			cfg_q.cmd_clear       <= DEF_CLEAR;
			cfg_q.cmd_entry_mode  <= DEF_ENTRY_MODE;
			cfg_q.cmd_display_on  <= DEF_DISP_ON;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POWER_UP:    cfg_q.power_up_ms     <= cfg_data;
				REG_STEP:        cfg_q.step_ms         <= cfg_data[7:0];
				REG_FORCE_RESET: cfg_q.cmd_force_reset <= cfg_data[7:0];
				REG_FOUR_BIT:    cfg_q.cmd_four_bit    <= cfg_data[7:0];
				REG_DISP_OFF:    cfg_q.cmd_display_off <= cfg_data[7:0];
				REG_CLEAR:       cfg_q.cmd_clear       <= cfg_data[7:0];
				REG_ENTRY_MODE:  cfg_q.cmd_entry_mode  <= cfg_data[7:0];
				REG_DISP_ON:     cfg_q.cmd_display_on  <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/lcd4_core.sv =====
// Sequencer state and next-state logic of the LCD driver.
module lcd4_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  opcode,
	input  logic [7:0]            char_byte,
	input  lcd4_pkg::lcd4_cfg_t   cfg,
	output lcd4_pkg::lcd4_res_t   res
);
	import lcd4_pkg::*;

	lcd4_state_t st_q;
	lcd4_state_t st_d;
	logic [9:0]  tc_inc;
	logic [9:0]  limit;
	logic        over;
	logic        fin;
	logic        accepted;
	logic        done;
	logic        inited;

	assign tc_inc = st_q.tick_count + 10'd1;
	assign limit  = (st_q.init_stage < STG_FIRST_CMD) ? cfg.power_up_ms : {2'b00, cfg.step_ms};
	assign over   = (tc_inc >= limit);

	always_comb begin
		st_d     = st_q;
		fin      = 1'b0;
		accepted = 1'b0;
		done     = 1'b0;
		if (opcode == OP_WRITE) begin
			if (st_q.init_stage >= STG_DONE && !st_q.sending_data) begin
				st_d              = start_byte(st_q, char_byte, 1'b1);
				st_d.sending_data = 1'b1;
				accepted          = 1'b1;
			end
		end else if (st_q.init_stage < STG_FIRST_CMD) begin
			st_d.tick_count = over ? 10'd0 : tc_inc;
			if (over) begin
				st_d.init_stage = st_q.init_stage + 4'd1;
				if (st_d.init_stage == STG_FIRST_CMD)
					st_d = start_byte(st_d, cmd_for_stage(st_d.init_stage, cfg), 1'b0);
			end
		end else if (st_q.init_stage < STG_DONE || st_q.sending_data) begin
			st_d.tick_count = over ? 10'd0 : tc_inc;
			if (over) begin
				case (st_q.nibble_phase)
					PH_HI_EN: begin
						st_d.en_level     = 1'b0;
						st_d.nibble_phase = PH_HI_LOW;
					end
					PH_HI_LOW: begin
						st_d.en_level     = 1'b1;
						st_d.nibble_level = st_q.held_byte[3:0];
						st_d.nibble_phase = PH_LO_EN;
					end
					PH_LO_EN: begin
						st_d.en_level     = 1'b0;
						st_d.nibble_phase = PH_LO_LOW;
					end
					PH_LO_LOW: begin
						// commands get a settle wait, data bytes end here
						if (st_q.init_stage < STG_DONE) begin
							st_d.nibble_phase = PH_SETTLE;
						end else begin
							st_d.nibble_phase = PH_HI_EN;
							fin               = 1'b1;
						end
					end
					default: begin
						st_d.nibble_phase = PH_HI_EN;
						fin               = 1'b1;
					end
				endcase
			end
			if (fin) begin
				if (st_q.init_stage < STG_DONE) begin
					st_d.init_stage = st_q.init_stage + 4'd1;
					if (st_d.init_stage < STG_DONE)
						st_d = start_byte(st_d, cmd_for_stage(st_d.init_stage, cfg), 1'b0);
				end else begin
					st_d.sending_data = 1'b0;
					done              = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	assign inited = (st_d.init_stage >= STG_DONE);

	always_comb begin
		res.reg_select     = st_d.rs_level;
		res.enable_pin     = st_d.en_level;
		res.bus_nibble     = st_d.nibble_level;
		res.init_done      = inited;
		res.busy_res       = !inited || st_d.sending_data;
		res.write_accepted = accepted;
		res.write_done     = done;
	end

endmodule

// ===== rtl/char_lcd_4bit_init_and_write.sv =====
// Top level of the 4-bit character LCD driver: handshakes, result register.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------------------------
//  request  | in_valid / in_ready  | opcode, char_byte
//  result   | out_valid / out_ready| reg_select, enable_pin, bus_nibble, init_done,
//           |                      | busy_res, write_accepted, write_done
//  config   | cfg_we               | cfg_idx, cfg_data
//
// One request per clock. The sequencer state updates at the edge that takes a
// request and its result lands in the result register at that same edge, where
// out_valid presents it. The single result register sets the rate: a new
// request is taken whenever that register is empty or being drained.
// A stall on out_ready holds the result and blocks requests until it drains.
// Reset puts the sequencer in its first power-up wait with all pins low and
// loads the register defaults.
module char_lcd_4bit_init_and_write (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] char_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       reg_select,
	output logic       enable_pin,
	output logic [3:0] bus_nibble,
	output logic       init_done,
	output logic       busy_res,
	output logic       write_accepted,
	output logic       write_done,
	// configuration writes
	input  logic       cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [9:0] cfg_data
);
	import lcd4_pkg::*;

	lcd4_cfg_t cfg;
	lcd4_res_t res;
	lcd4_res_t res_s1;
	logic      vld_s1;
	logic      take;

	// result register is free when empty or handing its result over now
	assign in_ready = !vld_s1 || out_ready;
	assign take     = in_valid && in_ready;

	lcd4_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	lcd4_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.opcode    (opcode),
		.char_byte (char_byte),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (take)
			res_s1 <= res;
	end

	assign out_valid      = vld_s1;
	assign reg_select     = res_s1.reg_select;
	assign enable_pin     = res_s1.enable_pin;
	assign bus_nibble     = res_s1.bus_nibble;
	assign init_done      = res_s1.init_done;
	assign busy_res       = res_s1.busy_res;
	assign write_accepted = res_s1.write_accepted;
	assign write_done     = res_s1.write_done;

endmodule

// ===== rtl/lcd4_checker.sv =====
// Port-level checker of the LCD driver and its bind.
`include "char_lcd_4bit_init_and_write_assert.svh"

module lcd4_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       reg_select,
	input logic       enable_pin,
	input logic [3:0] bus_nibble,
	input logic       init_done,
	input logic       busy_res,
	input logic       write_accepted,
	input logic       write_done
);

	// a taken write starts with RS and EN high and the block busy
	`LCD4_ASSERT_SAME(a_write_start, out_valid && write_accepted, init_done && busy_res && reg_select && enable_pin)

	// a finished write leaves EN low and the block free
	`LCD4_ASSERT_SAME(a_write_end, out_valid && write_done, init_done && !busy_res && !enable_pin && !write_accepted)

	// start-up only ever drives commands
	`LCD4_ASSERT_SAME(a_init_cmd, out_valid && !init_done, busy_res && !reg_select)

	// a stalled result holds
	`LCD4_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(bus_nibble) && $stable(enable_pin))

endmodule

bind char_lcd_4bit_init_and_write lcd4_checker u_lcd4_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.reg_select     (reg_select),
	.enable_pin     (enable_pin),
	.bus_nibble     (bus_nibble),
	.init_done      (init_done),
	.busy_res       (busy_res),
	.write_accepted (write_accepted),
	.write_done     (write_done)
);
